>>> hw/rtl/ordered_request_list_engine_macros.svh
// Assertion macros shared by the ordered request list engine.
`ifndef ORDERED_REQUEST_LIST_ENGINE_MACROS_SVH
`define ORDERED_REQUEST_LIST_ENGINE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ORLE_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ORLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/orle_pkg.sv
// Package with the types and codes of the ordered request list engine.
package orle_pkg;

    localparam int KEY_W       = 16;
    localparam int STAMP_W     = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QLVL_W      = 2;

    // Request kinds as they arrive on the input.
    localparam logic [1:0] REQ_APPEND  = 2'd0;
    localparam logic [1:0] REQ_SORT    = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;
    localparam logic [1:0] REQ_INVALID = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_SORT,
        OP_REMOVE,
        OP_INVALID
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_SORT,
        S_DUMP,
        S_ONE
    } t_state;

endpackage

>>> hw/rtl/orle_front.sv
// Front end: accepts requests, decodes their kind and queues them for the back end.
module orle_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [orle_pkg::KEY_W-1:0]   i_entry_key,
    input  logic [orle_pkg::STAMP_W-1:0] i_entry_stamp,
    output orle_pkg::t_cmd               o_cmd,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_take
);

    orle_pkg::t_cmd              r_q [orle_pkg::QUEUE_DEPTH];
    logic [orle_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [orle_pkg::QLVL_W-1:0] r_level;
    orle_pkg::t_cmd              w_dec;
    logic                        w_push, w_pop;

    // Decode the request kind.
    always_comb begin
        w_dec.key   = i_entry_key;
        w_dec.stamp = i_entry_stamp;
        unique case (i_req_type)
            orle_pkg::REQ_APPEND: w_dec.op = orle_pkg::OP_APPEND;
            orle_pkg::REQ_SORT:   w_dec.op = orle_pkg::OP_SORT;
            orle_pkg::REQ_REMOVE: w_dec.op = orle_pkg::OP_REMOVE;
            default:              w_dec.op = orle_pkg::OP_INVALID;
        endcase
    end

    assign o_stall     = (r_level == orle_pkg::QLVL_W'(orle_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_level != '0);
    assign o_cmd       = r_q[r_rd];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_dec;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!w_push && w_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/orle_back.sv
// Back end: holds the list in a row of cells and carries out queued requests.
module orle_back #(
    parameter int CAPACITY = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  orle_pkg::t_cmd             i_cmd,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_take,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic                       o_list_empty,
    output logic [orle_pkg::KEY_W-1:0] o_out_key,
    output logic                       o_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [orle_pkg::KEY_W-1:0]   r_key [CAPACITY];
    logic [orle_pkg::KEY_W-1:0]   n_key [CAPACITY];
    logic [orle_pkg::STAMP_W-1:0] r_stamp [CAPACITY];
    logic [orle_pkg::STAMP_W-1:0] n_stamp [CAPACITY];
    logic [orle_pkg::KEY_W-1:0]   rot_key [CAPACITY];
    logic [orle_pkg::STAMP_W-1:0] rot_stamp [CAPACITY];
    logic [orle_pkg::KEY_W-1:0]   sh_key [CAPACITY];
    logic [orle_pkg::STAMP_W-1:0] sh_stamp [CAPACITY];
    logic [CAPACITY-1:0]          w_swap;

    orle_pkg::t_state           r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_pos, n_pos;
    logic [CNT_W-1:0]           r_len, n_len;
    logic                       r_found, n_found;
    logic [1:0]                 r_err, n_err;
    logic [orle_pkg::KEY_W-1:0] r_arg, n_arg;

    logic                       r_ovalid, n_ovalid;
    logic [1:0]                 r_ostatus, n_ostatus;
    logic                       r_oempty, n_oempty;
    logic [orle_pkg::KEY_W-1:0] r_okey, n_okey;
    logic                       r_olast, n_olast;
    logic                       w_out_free;

    // Per-cell moves: rotate head to tail, drop the head, and compare-swap pairs.
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            if (j < CAPACITY - 1) begin
                sh_key[j]   = r_key[j+1];
                sh_stamp[j] = r_stamp[j+1];
            end else begin
                sh_key[j]   = r_key[j];
                sh_stamp[j] = r_stamp[j];
            end
            if (CNT_W'(j) == r_count - 1'b1) begin
                rot_key[j]   = r_key[0];
                rot_stamp[j] = r_stamp[0];
            end else begin
                rot_key[j]   = sh_key[j];
                rot_stamp[j] = sh_stamp[j];
            end
            w_swap[j] = 1'b0;
            if (j < CAPACITY - 1) begin
                if ((1'(j) == r_pos[0]) && (CNT_W'(j + 1) < r_count)) begin
                    if (r_stamp[j] != r_stamp[j+1]) begin
                        w_swap[j] = (r_stamp[j] > r_stamp[j+1]);
                    end else begin
                        w_swap[j] = (r_key[j] > r_key[j+1]);
                    end
                end
            end
        end
    end

    assign w_out_free = !r_ovalid || !i_stall;

    // Next state, list updates and output loading.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_len     = r_len;
        n_found   = r_found;
        n_err     = r_err;
        n_arg     = r_arg;
        n_key     = r_key;
        n_stamp   = r_stamp;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_oempty  = r_oempty;
        n_okey    = r_okey;
        n_olast   = r_olast;
        o_cmd_take = 1'b0;

        unique case (r_state)
            orle_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_arg      = i_cmd.key;
                    n_pos      = '0;
                    unique case (i_cmd.op)
                        orle_pkg::OP_APPEND: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_err   = orle_pkg::ST_FULL;
                                n_state = orle_pkg::S_ONE;
                            end else begin
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (CNT_W'(j) == r_count) begin
                                        n_key[j]   = i_cmd.key;
                                        n_stamp[j] = i_cmd.stamp;
                                    end
                                end
                                n_count = r_count + 1'b1;
                                n_state = orle_pkg::S_DUMP;
                            end
                        end
                        orle_pkg::OP_SORT: begin
                            n_state = orle_pkg::S_SORT;
                        end
                        orle_pkg::OP_REMOVE: begin
                            n_len   = r_count;
                            n_found = 1'b0;
                            n_state = orle_pkg::S_REMOVE;
                        end
                        default: begin
                            n_err   = orle_pkg::ST_INVALID;
                            n_state = orle_pkg::S_ONE;
                        end
                    endcase
                end
            end
            orle_pkg::S_REMOVE: begin
                if (r_pos == r_len) begin
                    n_pos = '0;
                    if (r_found) begin
                        n_state = orle_pkg::S_DUMP;
                    end else begin
                        n_err   = orle_pkg::ST_NOTFOUND;
                        n_state = orle_pkg::S_ONE;
                    end
                end else begin
                    // The first matching head is dropped; every other head goes to the tail.
                    if (!r_found && (r_key[0] == r_arg)) begin
                        n_key   = sh_key;
                        n_stamp = sh_stamp;
                        n_count = r_count - 1'b1;
                        n_found = 1'b1;
                    end else begin
                        n_key   = rot_key;
                        n_stamp = rot_stamp;
                    end
                    n_pos = r_pos + 1'b1;
                end
            end
            orle_pkg::S_SORT: begin
                if (r_pos >= r_count) begin
                    n_pos   = '0;
                    n_state = orle_pkg::S_DUMP;
                end else begin
                    // One odd-even transposition pass.
                    for (int j = 0; j < CAPACITY; j++) begin
                        if ((j < CAPACITY - 1) && w_swap[j]) begin
                            n_key[j]   = r_key[j+1];
                            n_stamp[j] = r_stamp[j+1];
                        end
                        if ((j > 0) && w_swap[j-1]) begin
                            n_key[j]   = r_key[j-1];
                            n_stamp[j] = r_stamp[j-1];
                        end
                    end
                    n_pos = r_pos + 1'b1;
                end
            end
            orle_pkg::S_DUMP: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = orle_pkg::ST_OK;
                    if (r_count == '0) begin
                        n_oempty = 1'b1;
                        n_okey   = '0;
                        n_olast  = 1'b1;
                        n_state  = orle_pkg::S_IDLE;
                    end else begin
                        // Emit the head and rotate it to the tail.
                        n_oempty = 1'b0;
                        n_okey   = r_key[0];
                        n_olast  = (r_pos == r_count - 1'b1);
                        n_key    = rot_key;
                        n_stamp  = rot_stamp;
                        n_pos    = r_pos + 1'b1;
                        if (r_pos == r_count - 1'b1) begin
                            n_state = orle_pkg::S_IDLE;
                        end
                    end
                end
            end
            orle_pkg::S_ONE: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_err;
                    n_oempty  = (r_count == '0);
                    n_okey    = '0;
                    n_olast   = 1'b1;
                    n_state   = orle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = orle_pkg::S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= orle_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // List cells, work registers and output payload.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_stamp   <= n_stamp;
        r_pos     <= n_pos;
        r_len     <= n_len;
        r_found   <= n_found;
        r_err     <= n_err;
        r_arg     <= n_arg;
        r_ostatus <= n_ostatus;
        r_oempty  <= n_oempty;
        r_okey    <= n_okey;
        r_olast   <= n_olast;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_list_empty = r_oempty;
    assign o_out_key    = r_okey;
    assign o_last       = r_olast;

endmodule

>>> hw/rtl/ordered_request_list_engine.sv
// Top level of the ordered request list engine.
//
//  Channel   Direction  Handshake         Payload
//  request   in         i_valid/o_stall   i_req_type, i_entry_key, i_entry_stamp
//  result    out        o_valid/i_stall   o_status, o_list_empty, o_out_key, o_last
//
// The back end walks the list one cell step a cycle, but a dump step waits while the result
// output is stalled: one rotation or head drop per remove step, one transposition pass per
// sort step, one key per dump step.
// Reset clears the entry count, the control state and the handshake state only; the list cells hold no reset.
// Up to two decoded requests wait in the front queue while the back end works.
`include "ordered_request_list_engine_macros.svh"

module ordered_request_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic [orle_pkg::KEY_W-1:0]   i_entry_key,
    input  logic [orle_pkg::STAMP_W-1:0] i_entry_stamp,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic                         o_list_empty,
    output logic [orle_pkg::KEY_W-1:0]   o_out_key,
    output logic                         o_last
);

    orle_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_take;

    // Request intake and queue.
    orle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_entry_key   (i_entry_key),
        .i_entry_stamp (i_entry_stamp),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_take    (w_cmd_take)
    );

    // List execution and result output.
    orle_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_take   (w_cmd_take),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_list_empty (o_list_empty),
        .o_out_key    (o_out_key),
        .o_last       (o_last)
    );

    // The back end only takes a request that the queue offers.
    `ORLE_ASSERT(a_take_offered, !w_cmd_take || w_cmd_valid, "request taken from empty queue")
    // Error results are always single items.
    `ORLE_ASSERT_IMP(a_err_last, o_valid && (o_status != orle_pkg::ST_OK), o_last && (o_out_key == '0), "error result not single")
    // An empty list result is a single item with a zero key.
    `ORLE_ASSERT_IMP(a_empty_last, o_valid && o_list_empty, o_last && (o_out_key == '0), "empty result not single")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the ordered request list engine.
`timescale 1ns / 1ps

module tb;

    localparam int CAP       = 32;
    localparam int CYCLE_MAX = 400000;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [orle_pkg::KEY_W-1:0]   key;
        logic [orle_pkg::STAMP_W-1:0] stamp;
    } t_req;

    typedef struct packed {
        logic [1:0]                 status;
        logic                       empty;
        logic [orle_pkg::KEY_W-1:0] key;
        logic                       last;
    } t_res;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [1:0]                   i_req_type;
    logic [orle_pkg::KEY_W-1:0]   i_entry_key;
    logic [orle_pkg::STAMP_W-1:0] i_entry_stamp;
    logic                         o_valid;
    logic                         i_stall;
    logic [1:0]                   o_status;
    logic                         o_list_empty;
    logic [orle_pkg::KEY_W-1:0]   o_out_key;
    logic                         o_last;

    t_req pending_reqs[$];
    t_res expected_keys[$];

    // Shadow copy of the list.
    logic [orle_pkg::KEY_W-1:0]   shadow_keys[CAP];
    logic [orle_pkg::STAMP_W-1:0] shadow_stamps[CAP];
    int                           shadow_count = 0;

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  hold_cycles;
    bit  hold_req      = 1'b0;
    bit  hold_done;
    int  errors        = 0;
    int  cycles        = 0;

    ordered_request_list_engine #(.CAPACITY(CAP)) uut (.*);

    // Clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Pushes one error-style result.
    function automatic void push_single(logic [1:0] st, logic emp);
        t_res r;
        r.status = st;
        r.empty  = emp;
        r.key    = '0;
        r.last   = 1'b1;
        expected_keys.push_back(r);
    endfunction

    // Applies one request to the shadow list and queues the expected dump.
    function automatic void predict_list(t_req rq);
        int                           i;
        int                           j;
        int                           hit;
        logic [orle_pkg::KEY_W-1:0]   tk;
        logic [orle_pkg::STAMP_W-1:0] ts;
        t_res                         r;
        hit = -1;
        case (rq.kind)
            orle_pkg::REQ_APPEND: begin
                if (shadow_count >= CAP) begin
                    push_single(orle_pkg::ST_FULL, shadow_count == 0);
                    return;
                end
                shadow_keys[shadow_count]   = rq.key;
                shadow_stamps[shadow_count] = rq.stamp;
                shadow_count++;
            end
            orle_pkg::REQ_SORT: begin
                for (i = 1; i < shadow_count; i++) begin
                    for (j = i; j > 0; j--) begin
                        if (shadow_stamps[j-1] > shadow_stamps[j] ||
                            (shadow_stamps[j-1] == shadow_stamps[j] &&
                             shadow_keys[j-1] > shadow_keys[j])) begin
                            tk = shadow_keys[j-1];
                            ts = shadow_stamps[j-1];
                            shadow_keys[j-1]   = shadow_keys[j];
                            shadow_stamps[j-1] = shadow_stamps[j];
                            shadow_keys[j]     = tk;
                            shadow_stamps[j]   = ts;
                        end else begin
                            break;
                        end
                    end
                end
            end
            orle_pkg::REQ_REMOVE: begin
                for (i = 0; i < shadow_count; i++) begin
                    if (hit < 0 && shadow_keys[i] == rq.key) hit = i;
                end
                if (hit < 0) begin
                    push_single(orle_pkg::ST_NOTFOUND, shadow_count == 0);
                    return;
                end
                for (i = hit; i + 1 < shadow_count; i++) begin
                    shadow_keys[i]   = shadow_keys[i+1];
                    shadow_stamps[i] = shadow_stamps[i+1];
                end
                shadow_count--;
            end
            default: begin
                push_single(orle_pkg::ST_INVALID, shadow_count == 0);
                return;
            end
        endcase
        if (shadow_count == 0) begin
            push_single(orle_pkg::ST_OK, 1'b1);
            return;
        end
        for (i = 0; i < shadow_count; i++) begin
            r.status = orle_pkg::ST_OK;
            r.empty  = 1'b0;
            r.key    = shadow_keys[i];
            r.last   = (i + 1 == shadow_count);
            expected_keys.push_back(r);
        end
    endfunction

    function automatic void add_req(logic [1:0] k, logic [orle_pkg::KEY_W-1:0] key,
                                    logic [orle_pkg::STAMP_W-1:0] st);
        t_req rq;
        rq.kind  = k;
        rq.key   = key;
        rq.stamp = st;
        pending_reqs.push_back(rq);
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_req_type    <= '0;
            i_entry_key   <= '0;
            i_entry_stamp <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_list('{i_req_type, i_entry_key, i_entry_stamp});
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req rq;
                rq = pending_reqs.pop_front();
                i_valid       <= 1'b1;
                i_req_type    <= rq.kind;
                i_entry_key   <= rq.key;
                i_entry_stamp <= rq.stamp;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result stall generator, with one long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_cycles <= 300;
            hold_done   <= 1'b1;
            i_stall     <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_keys.size() == 0) begin
                $error("unexpected result: status %0d key %0h", o_status, o_out_key);
                errors++;
            end else begin
                exp_r = expected_keys.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_list_empty !== exp_r.empty) begin
                    $error("list_empty: expected %0d, actual %0d", exp_r.empty, o_list_empty);
                    errors++;
                end
                if (o_out_key !== exp_r.key) begin
                    $error("out_key: expected %0h, actual %0h", exp_r.key, o_out_key);
                    errors++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, actual %0d", exp_r.last, o_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Waits until every queued request has been taken by the block.
    task automatic drain_reqs();
        while (pending_reqs.size() > 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Random phase: mostly appends and removes of live keys, some sorts and noise.
    task automatic random_phase(int count);
        int                         n;
        int                         sel;
        logic [orle_pkg::KEY_W-1:0] k;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            k = 16'($urandom);
            if (sel < 45) begin
                add_req(orle_pkg::REQ_APPEND, ($urandom_range(3) == 0) ? k : (k & 16'h000f),
                        ($urandom_range(2) == 0) ? 20'($urandom) : 20'($urandom_range(7)));
            end else if (sel < 60) begin
                add_req(orle_pkg::REQ_SORT, k, 20'($urandom));
            end else if (sel < 90) begin
                add_req(orle_pkg::REQ_REMOVE, ($urandom_range(4) == 0) ? k : (k & 16'h000f),
                        20'($urandom));
            end else begin
                add_req(orle_pkg::REQ_INVALID, k, 20'($urandom));
            end
        end
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases, extremes, tie ordering and a full list.
        add_req(orle_pkg::REQ_SORT, 16'h0000, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'h1234, 20'h0);
        add_req(orle_pkg::REQ_INVALID, 16'hffff, 20'hfffff);
        add_req(orle_pkg::REQ_APPEND, 16'hffff, 20'hfffff);
        add_req(orle_pkg::REQ_APPEND, 16'h0000, 20'h00000);
        add_req(orle_pkg::REQ_APPEND, 16'h0005, 20'h00010);
        add_req(orle_pkg::REQ_APPEND, 16'h0003, 20'h00010);
        add_req(orle_pkg::REQ_SORT, 16'h0000, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'h0003, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'h7777, 20'h0);
        add_req(orle_pkg::REQ_INVALID, 16'h0000, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'hffff, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'h0000, 20'h0);
        add_req(orle_pkg::REQ_REMOVE, 16'h0005, 20'h0);
        for (i = 0; i < 33; i++)
            add_req(orle_pkg::REQ_APPEND, 16'(i * 7 % 5), 20'(32 - i));
        add_req(orle_pkg::REQ_SORT, 16'h0, 20'h0);
        for (i = 0; i < 30; i++)
            add_req(orle_pkg::REQ_REMOVE, 16'(i % 5), 20'h0);

        // Idling phases, one with a long receiver hold-off.
        random_phase(30);
        drain_reqs();
        send_idle_pct = 68;
        random_phase(30);
        drain_reqs();
        send_idle_pct = 0;
        stall_pct     = 68;
        random_phase(30);
        drain_reqs();
        stall_pct = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        random_phase(12);
        drain_reqs();
        send_idle_pct = 28;
        stall_pct     = 28;
        random_phase(30);
        drain_reqs();

        while (expected_keys.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_keys.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
